@@ src/blsf_pkg.sv @@
// Package for the button link session controller.
// Holds the mode, event, item-kind and config-index codes, the register defaults
// and the channel payload types. No dependencies.
`timescale 1ns / 1ps

package blsf_pkg;

  localparam int unsigned CFG_W = 20;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_CONN  = 2'd2,
    MODE_SEND  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_LONG    = 3'd2,
    EV_FAIL    = 3'd3,
    EV_CONNECT = 3'd4,
    EV_ACKOK   = 3'd5,
    EV_TIMEOUT = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_LINK   = 2'd2,
    KIND_ACK    = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONNECT_TO = 2'd0,
    CFG_INACT_TO   = 2'd1,
    CFG_ACK_TO     = 2'd2,
    CFG_HOLD_THR   = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] CONNECT_TO_RST = 20'd10000;
  localparam logic [CFG_W-1:0] INACT_TO_RST   = 20'd10000;
  localparam logic [CFG_W-1:0] ACK_TO_RST     = 20'd2000;
  localparam logic [CFG_W-1:0] HOLD_THR_RST   = 20'd1000;

  typedef struct packed {
    logic [1:0] kind;
    logic       level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       key_req;
    logic [2:0] event_res;
    logic       held;
  } out_item_t;

endpackage

@@ src/blsf_stream_if.sv @@
// Valid/ready stream interface used for the input and result channels.
// Payload type is a parameter; payload structs come from blsf_pkg.
`timescale 1ns / 1ps

interface blsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/button_link_session_fsm_unit.sv @@
// Button link session controller, top level.
// Depends on blsf_pkg and blsf_stream_if.
//
// Usage:
//   in_i  (sink)   : one transaction per event: kind (tick, button, link, ack)
//                    and level. A tick stands for one millisecond.
//   out_o (source) : one transaction per accepted input: mode, key_req,
//                    event_res and held as they are after that input.
//   cfg_*          : plain write port for the four timeout / press registers,
//                    written by the user only while no transaction is in flight; the block does not check this.
// Path: an accepted input is held in the input register; its result is then
//   registered in the result register, which drives out_o. Throughput: one
//   transaction per cycle while out_o.ready does not stall the result register;
//   the state update is a single pass of compare and increment logic between
//   the input register and the result/state registers.
// Stall: when out_o.ready is low the result register holds; one more input
//   may sit in the input register, after which in_i.ready drops.
// Reset: mode sleep, all ages zero, not held, key_req low, registers at
//   their defaults (10000, 10000, 2000, 1000), both stages empty.
`timescale 1ns / 1ps

module button_link_session_fsm_unit #(
  parameter int unsigned AGE_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  blsf_stream_if.sink                   in_i,
  blsf_stream_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic [blsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [blsf_pkg::CFG_W-1:0]     cfg_data_i
);

  // Compare width covers both the age counters and the 20-bit registers.
  localparam int unsigned CMP_W =
    (AGE_BITS > blsf_pkg::CFG_W) ? AGE_BITS : blsf_pkg::CFG_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // ---------------- configuration registers ----------------
  logic [blsf_pkg::CFG_W-1:0] connect_to_q, inact_to_q, ack_to_q, hold_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connect_to_q <= blsf_pkg::CONNECT_TO_RST;
      inact_to_q   <= blsf_pkg::INACT_TO_RST;
      ack_to_q     <= blsf_pkg::ACK_TO_RST;
      hold_thr_q   <= blsf_pkg::HOLD_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        blsf_pkg::CFG_CONNECT_TO: connect_to_q <= cfg_data_i;
        blsf_pkg::CFG_INACT_TO:   inact_to_q   <= cfg_data_i;
        blsf_pkg::CFG_ACK_TO:     ack_to_q     <= cfg_data_i;
        blsf_pkg::CFG_HOLD_THR:   hold_thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic               item_valid_q;
  blsf_pkg::in_item_t item_q;
  logic               out_valid_q;
  blsf_pkg::out_item_t out_q, out_d;
  logic               out_free;
  logic               adv;

  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = item_valid_q && out_free;
  assign in_i.ready = !item_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
  end

  // ---------------- session state ----------------
  blsf_pkg::mode_e     mode_q, mode_d;
  logic [AGE_BITS-1:0] mode_age_q, mode_age_d;
  logic [AGE_BITS-1:0] press_age_q, press_age_d;
  logic [AGE_BITS-1:0] idle_age_q, idle_age_d;
  logic                held_q, held_d;
  logic                key_req_q, key_req_d;
  blsf_pkg::event_e    ev;

  // Saturating increments, computed up front for the tick path.
  logic [AGE_BITS-1:0] mode_age_inc, press_age_inc, idle_age_inc;
  assign mode_age_inc  = (mode_age_q  == AGE_MAX) ? mode_age_q  : mode_age_q  + 1'b1;
  assign press_age_inc = (press_age_q == AGE_MAX) ? press_age_q : press_age_q + 1'b1;
  assign idle_age_inc  = (idle_age_q  == AGE_MAX) ? idle_age_q  : idle_age_q  + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= blsf_pkg::MODE_SLEEP;
      mode_age_q  <= '0;
      press_age_q <= '0;
      idle_age_q  <= '0;
      held_q      <= 1'b0;
      key_req_q   <= 1'b0;
    end else if (adv) begin
      mode_q      <= mode_d;
      mode_age_q  <= mode_age_d;
      press_age_q <= press_age_d;
      idle_age_q  <= idle_age_d;
      held_q      <= held_d;
      key_req_q   <= key_req_d;
    end
  end

  // Event derivation, then the mode transition the event drives.
  always_comb begin
    ev          = blsf_pkg::EV_NONE;
    mode_age_d  = mode_age_q;
    press_age_d = press_age_q;
    idle_age_d  = idle_age_q;
    held_d      = held_q;
    key_req_d   = key_req_q;
    mode_d      = mode_q;

    case (item_q.kind)
      blsf_pkg::KIND_TICK: begin
        mode_age_d  = mode_age_inc;
        press_age_d = press_age_inc;
        idle_age_d  = idle_age_inc;
        // Timeouts compare the already incremented ages.
        if (mode_q == blsf_pkg::MODE_WAIT &&
            CMP_W'(mode_age_inc) > CMP_W'(connect_to_q)) begin
          ev = blsf_pkg::EV_TIMEOUT;
        end else if (mode_q == blsf_pkg::MODE_CONN &&
                     CMP_W'(idle_age_inc) > CMP_W'(inact_to_q)) begin
          ev = blsf_pkg::EV_FAIL;
        end else if (mode_q == blsf_pkg::MODE_SEND &&
                     CMP_W'(mode_age_inc) > CMP_W'(ack_to_q)) begin
          ev = blsf_pkg::EV_TIMEOUT;
        end
      end
      blsf_pkg::KIND_BUTTON: begin
        if (item_q.level && !held_q) begin
          held_d      = 1'b1;
          press_age_d = '0;
          idle_age_d  = '0;
        end else if (!item_q.level && held_q) begin
          held_d     = 1'b0;
          idle_age_d = '0;
          ev = (CMP_W'(press_age_q) < CMP_W'(hold_thr_q)) ?
               blsf_pkg::EV_SHORT : blsf_pkg::EV_LONG;
        end
      end
      blsf_pkg::KIND_LINK: begin
        idle_age_d = '0;
        ev = item_q.level ? blsf_pkg::EV_CONNECT : blsf_pkg::EV_FAIL;
      end
      default: begin
        idle_age_d = '0;
        ev = item_q.level ? blsf_pkg::EV_ACKOK : blsf_pkg::EV_TIMEOUT;
      end
    endcase

    case (mode_q)
      blsf_pkg::MODE_SLEEP: begin
        if (ev == blsf_pkg::EV_LONG) begin
          mode_d = blsf_pkg::MODE_WAIT;
        end
      end
      blsf_pkg::MODE_WAIT: begin
        if (ev == blsf_pkg::EV_CONNECT) begin
          mode_d    = blsf_pkg::MODE_CONN;
          key_req_d = 1'b0;
        end else if (ev == blsf_pkg::EV_TIMEOUT || ev == blsf_pkg::EV_FAIL) begin
          mode_d = blsf_pkg::MODE_SLEEP;
        end
      end
      blsf_pkg::MODE_CONN: begin
        if (ev == blsf_pkg::EV_SHORT) begin
          mode_d    = blsf_pkg::MODE_SEND;
          key_req_d = 1'b1;
        end else if (ev == blsf_pkg::EV_FAIL) begin
          mode_d = blsf_pkg::MODE_SLEEP;
        end
      end
      default: begin
        if (ev == blsf_pkg::EV_ACKOK || ev == blsf_pkg::EV_TIMEOUT) begin
          mode_d    = blsf_pkg::MODE_SLEEP;
          key_req_d = 1'b0;
        end
      end
    endcase

    // Any mode change restarts the mode age.
    if (mode_d != mode_q) begin
      mode_age_d = '0;
    end

    out_d.mode      = mode_d;
    out_d.key_req   = key_req_d;
    out_d.event_res = ev;
    out_d.held      = held_d;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------- assertions ----------------
  // key_req is raised only on entry to send-key and dropped on leaving it.
  a_key_req_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_req_q == (mode_q == blsf_pkg::MODE_SEND))
    else $error("key_req out of step with mode");

  // A mode change always restarts the mode age.
  a_mode_age_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != $past(mode_q)) |-> (mode_age_q == '0))
    else $error("mode age not cleared on mode change");

  // A press event is a release, so the button reads as not held.
  a_press_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_res == blsf_pkg::EV_SHORT ||
                     out_q.event_res == blsf_pkg::EV_LONG)) |-> !out_q.held)
    else $error("press event reported while held");

  // State only moves when an item leaves the input register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(held_q) && $stable(mode_q))
    else $error("state changed without an item");

endmodule
